@@ src/fdtd_wave_stencil_3d_assert.svh @@
// ----------------------------------------------------------------------------
// fdtd_wave_stencil_3d_assert.svh
// Assertion macros used by the stencil checker.
// ----------------------------------------------------------------------------
`ifndef FDTD_WAVE_STENCIL_3D_ASSERT_SVH
`define FDTD_WAVE_STENCIL_3D_ASSERT_SVH

// same-cycle implication, muted during reset
`define FWS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("fws check failed");

// next-cycle implication, muted during reset
`define FWS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("fws check failed");

// next-cycle implication, live through reset
`define FWS_ASSERT_RNXT(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("fws check failed");

`endif

@@ src/fws_pkg.sv @@
// ----------------------------------------------------------------------------
// fws_pkg
// Types and constants of the 3D wave stencil.
// ----------------------------------------------------------------------------
package fws_pkg;

  localparam int P_W      = 32;  // pressure, Q12.20
  localparam int GAIN_W   = 24;  // gains, unsigned Q2.22
  localparam int DIM_W    = 7;
  localparam int DEPTH_W  = 16;
  localparam int PLANE_W  = 17;  // plane counter reaches depth
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [DIM_W-1:0]   RST_WIDTH  = 7'd64;
  localparam logic [DIM_W-1:0]   RST_HEIGHT = 7'd64;
  localparam logic [DEPTH_W-1:0] RST_DEPTH  = 16'd64;
  localparam logic [GAIN_W-1:0]  RST_NORM   = 24'd4194304;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_DEPTH  = 3'd2,
    REG_LAP    = 3'd3,
    REG_DAMP   = 3'd4,
    REG_NORM   = 3'd5,
    REG_FORCE  = 3'd6
  } fws_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [DEPTH_W-1:0] depth;
    logic [GAIN_W-1:0]  lap;
    logic [GAIN_W-1:0]  damp;
    logic [GAIN_W-1:0]  norm;
    logic [GAIN_W-1:0]  force_g;
  } fws_cfg_t;

  // neighbourhood of one cell, out-of-grid taps already zeroed
  typedef struct packed {
    logic           last;
    logic [P_W-1:0] up;
    logic [P_W-1:0] c;
    logic [P_W-1:0] xl;
    logic [P_W-1:0] xr;
    logic [P_W-1:0] yl;
    logic [P_W-1:0] yr;
    logic [P_W-1:0] zl;
    logic [P_W-1:0] po;
    logic [P_W-1:0] fo;
  } fws_tap_t;

endpackage

@@ src/fws_ram.sv @@
// ----------------------------------------------------------------------------
// fws_ram
// Simple dual-port RAM, one write and one registered read (read-first).
// ----------------------------------------------------------------------------
module fws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/fws_fetch.sv @@
// ----------------------------------------------------------------------------
// fws_fetch
// Raster counters, plane buffers and neighbourhood fetch (first stage).
// ----------------------------------------------------------------------------
module fws_fetch #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fws_pkg::fws_cfg_t         cfg,
  input  logic                      acc,
  input  logic [fws_pkg::P_W-1:0]   pres_now,
  input  logic [fws_pkg::P_W-1:0]   pres_before,
  input  logic [fws_pkg::P_W-1:0]   force_in,
  input  logic                      is_padding,
  input  logic                      en1,
  output logic                      v1,
  output fws_pkg::fws_tap_t         tap
);
  import fws_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int PA    = $clog2(CELLS);
  localparam int AW    = $clog2(2 * CELLS);
  localparam int NRD   = 6;  // center, x-1, x+1, y-1, y+1, lower plane

  logic [XW-1:0]      col_r, col_nxt;
  logic [YW-1:0]      row_r, row_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;

  logic [DW-1:0]      w_eff;
  logic [HW-1:0]      h_eff;
  logic [PLANE_W-1:0] d_eff;
  logic               pad, emit, x_end, y_end;
  logic               xm, xp, ym, yp, zm, last;
  logic [PA-1:0]      pos;
  logic [P_W-1:0]     p_in, old_in, f_in;
  logic [AW-1:0]      cs_base, in_base;
  logic [AW-1:0]      raddr [NRD];
  logic [P_W-1:0]     rdata [NRD];
  logic [P_W-1:0]     po_rd, fo_rd;

  logic               v1_r;
  logic [4:0]         msk_r;  // zm, yp, ym, xp, xm
  logic               last_r;
  logic [P_W-1:0]     up_r;

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = DW'(1);
    end else if (int'(cfg.width) > MAX_WIDTH) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(cfg.width);
    end
    if (cfg.height == '0) begin
      h_eff = HW'(1);
    end else if (int'(cfg.height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg.height);
    end
    d_eff = (cfg.depth == '0) ? PLANE_W'(1) : PLANE_W'(cfg.depth);
  end

  assign x_end = (int'(col_r) + 1) >= int'(w_eff);
  assign y_end = (int'(row_r) + 1) >= int'(h_eff);
  assign xm    = col_r != '0;
  assign xp    = !x_end;
  assign ym    = row_r != '0;
  assign yp    = !y_end;
  assign zm    = plane_r > PLANE_W'(1);
  assign pad   = is_padding || (plane_r >= d_eff);
  assign emit  = (plane_r != '0) && (plane_r <= d_eff);
  assign last  = ((int'(col_r) + 1) == int'(w_eff)) &&
                 ((int'(row_r) + 1) == int'(h_eff)) && (plane_r == d_eff);

  assign pos    = PA'(int'(row_r) * MAX_WIDTH + int'(col_r));
  assign p_in   = pad ? '0 : pres_now;
  assign old_in = pad ? '0 : pres_before;
  assign f_in   = pad ? '0 : force_in;

  // two plane slots, chosen by plane parity
  assign in_base = plane_r[0] ? AW'(CELLS) : '0;
  assign cs_base = plane_r[0] ? '0 : AW'(CELLS);

  always_comb begin
    raddr[0] = cs_base + AW'(pos);
    raddr[1] = cs_base + AW'(PA'(pos - PA'(1)));
    raddr[2] = cs_base + AW'(PA'(pos + PA'(1)));
    raddr[3] = cs_base + AW'(PA'(pos - PA'(MAX_WIDTH)));
    raddr[4] = cs_base + AW'(PA'(pos + PA'(MAX_WIDTH)));
    raddr[5] = in_base + AW'(pos);
  end

  // one copy of the pressure planes per read tap, all written alike
  for (genvar i = 0; i < NRD; i++) begin : g_pbuf
    fws_ram #(.WIDTH(P_W), .DEPTH(2 * CELLS)) u_pbuf (
      .clk   (clk),
      .we    (acc),
      .waddr (in_base + AW'(pos)),
      .wdata (p_in),
      .re    (en1),
      .raddr (raddr[i]),
      .rdata (rdata[i])
    );
  end

  fws_ram #(.WIDTH(P_W), .DEPTH(CELLS)) u_prev (
    .clk   (clk),
    .we    (acc),
    .waddr (pos),
    .wdata (old_in),
    .re    (en1),
    .raddr (pos),
    .rdata (po_rd)
  );

  fws_ram #(.WIDTH(P_W), .DEPTH(CELLS)) u_force (
    .clk   (clk),
    .we    (acc),
    .waddr (pos),
    .wdata (f_in),
    .re    (en1),
    .raddr (pos),
    .rdata (fo_rd)
  );

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    plane_nxt = plane_r;
    if (acc) begin
      if (x_end) begin
        col_nxt = '0;
        if (y_end) begin
          row_nxt   = '0;
          plane_nxt = (plane_r >= d_eff) ? '0 : plane_r + PLANE_W'(1);
        end else begin
          row_nxt = row_r + YW'(1);
        end
      end else begin
        col_nxt = col_r + XW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      plane_r <= '0;
      v1_r    <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      plane_r <= plane_nxt;
      if (en1) begin
        v1_r <= acc && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      msk_r  <= {zm, yp, ym, xp, xm};
      last_r <= last;
      up_r   <= p_in;
    end
  end

  assign v1 = v1_r;

  always_comb begin
    tap.last = last_r;
    tap.up   = up_r;
    tap.c    = rdata[0];
    tap.xl   = msk_r[0] ? rdata[1] : '0;
    tap.xr   = msk_r[1] ? rdata[2] : '0;
    tap.yl   = msk_r[2] ? rdata[3] : '0;
    tap.yr   = msk_r[3] ? rdata[4] : '0;
    tap.zl   = msk_r[4] ? rdata[5] : '0;
    tap.po   = po_rd;
    tap.fo   = fo_rd;
  end

endmodule

@@ src/fws_arith.sv @@
// ----------------------------------------------------------------------------
// fws_arith
// Six-stage fixed-point update: Laplacian, gain products, rounding, norm.
// ----------------------------------------------------------------------------
module fws_arith (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fws_pkg::fws_cfg_t                 cfg,
  input  logic                              v1,
  input  fws_pkg::fws_tap_t                 tap,
  output logic                              en1,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fws_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);
  import fws_pkg::*;

  localparam logic signed [44:0] SAT_MAX = 45'sd2147483647;
  localparam logic signed [44:0] SAT_MIN = -45'sd2147483648;

  logic [7:2] v_r;
  logic [7:1] en;
  logic [7:2] last_r;

  // stage 2
  logic signed [33:0] sa_r, sb_r;
  logic signed [31:0] c2_r, po2_r, fo2_r;
  // stage 3
  logic signed [35:0] lap_r;
  logic signed [33:0] t3_r;
  logic signed [31:0] po3_r, fo3_r;
  // stage 4
  logic signed [60:0] pl_r;
  logic signed [56:0] pd_r, pf_r;
  logic signed [55:0] tt_r;
  // stage 5
  logic signed [62:0] acc5;
  logic signed [40:0] s5_r;
  // stage 6
  logic [43:0]        plo_r;
  logic signed [45:0] phi_r;
  // stage 7
  logic signed [66:0] tot7;
  logic signed [44:0] r7;
  logic [P_W-1:0]     res_r;

  // stall chain from the output back to the fetch stage
  always_comb begin
    en[7] = !v_r[7] || out_tready;
    for (int k = 6; k >= 2; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    en[1] = !v1 || en[2];
  end
  assign en1 = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[2]) v_r[2] <= v1;
      for (int k = 3; k <= 7; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) last_r[2] <= tap.last;
    for (int k = 3; k <= 7; k++) begin
      if (en[k]) last_r[k] <= last_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sa_r  <= 34'($signed(tap.xl)) + 34'($signed(tap.xr)) + 34'($signed(tap.yl));
      sb_r  <= 34'($signed(tap.yr)) + 34'($signed(tap.zl)) + 34'($signed(tap.up));
      c2_r  <= $signed(tap.c);
      po2_r <= $signed(tap.po);
      fo2_r <= $signed(tap.fo);
    end
    if (en[3]) begin
      // six neighbours minus 6*center
      lap_r <= 36'(sa_r) + 36'(sb_r) - (36'(c2_r) <<< 2) - (36'(c2_r) <<< 1);
      t3_r  <= (34'(c2_r) <<< 1) - 34'(po2_r);
      po3_r <= po2_r;
      fo3_r <= fo2_r;
    end
    if (en[4]) begin
      pl_r <= lap_r * $signed({1'b0, cfg.lap});
      pd_r <= po3_r * $signed({1'b0, cfg.damp});
      pf_r <= fo3_r * $signed({1'b0, cfg.force_g});
      tt_r <= {t3_r, 22'b0};
    end
    if (en[5]) begin
      s5_r <= acc5[62:22];
    end
    if (en[6]) begin
      // norm product split in two halves of s
      plo_r <= s5_r[19:0] * cfg.norm;
      phi_r <= $signed(s5_r[40:20]) * $signed({1'b0, cfg.norm});
    end
    if (en[7]) begin
      if (r7 > SAT_MAX) begin
        res_r <= SAT_MAX[P_W-1:0];
      end else if (r7 < SAT_MIN) begin
        res_r <= SAT_MIN[P_W-1:0];
      end else begin
        res_r <= r7[P_W-1:0];
      end
    end
  end

  assign acc5 = 63'(tt_r) + 63'(pl_r) + 63'(pd_r) + 63'(pf_r) + 63'(2 ** 21);
  assign tot7 = 67'($signed({phi_r, 20'b0})) + 67'($signed({1'b0, plo_r})) + 67'(2 ** 21);
  assign r7   = tot7[66:22];

  assign out_tvalid = v_r[7];
  assign out_tdata  = res_r;
  assign out_tlast  = last_r[7];

endmodule

@@ src/fdtd_wave_stencil_3d.sv @@
// ----------------------------------------------------------------------------
// fdtd_wave_stencil_3d
// One time step of a damped 3D acoustic wave, 7-point stencil, streamed.
// ----------------------------------------------------------------------------
// Cells enter on the in_ stream in raster order (x fastest, then y, then z),
// one beat per cycle while in_tready is high. The result for cell (x,y,z) is
// computed when the beat of cell (x,y,z+1) is taken, passes the fetch
// register and the six arithmetic stages and leaves on the out_ stream;
// beats of plane 0 give no result. After the last plane send one plane of
// padding beats (in_tuser high) to flush it; out_tlast marks the last cell
// of the grid. Throughput is one beat per cycle unless out_ stalls: every
// plane-buffer read port has its own RAM copy, so all taps of a cell are
// fetched in the cycle it is accepted. A stalled out_ stream fills the
// pipeline, then in_tready drops; it keeps accepting while any stage is empty.
// Reset clears the position counters and pipeline valids and loads the
// default registers; plane buffers are not cleared and hold data only once
// written by the stream. The user writes registers through cfg_ only while
// the stream is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module fdtd_wave_stencil_3d #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // pressure_now[31:0], pressure_before[63:32], force_in[95:64]
  input  logic [fws_pkg::IN_TDATA_W-1:0]      in_tdata,
  // is_padding[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // new_pressure[31:0]
  output logic [fws_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [fws_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [fws_pkg::GAIN_W-1:0]          cfg_wdata
);
  import fws_pkg::*;

  fws_cfg_t cfg_r, cfg_nxt;
  fws_tap_t tap;
  logic     v1, en1, acc;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (fws_reg_t'(cfg_addr))
        REG_WIDTH:  cfg_nxt.width   = cfg_wdata[DIM_W-1:0];
        REG_HEIGHT: cfg_nxt.height  = cfg_wdata[DIM_W-1:0];
        REG_DEPTH:  cfg_nxt.depth   = cfg_wdata[DEPTH_W-1:0];
        REG_LAP:    cfg_nxt.lap     = cfg_wdata;
        REG_DAMP:   cfg_nxt.damp    = cfg_wdata;
        REG_NORM:   cfg_nxt.norm    = cfg_wdata;
        REG_FORCE:  cfg_nxt.force_g = cfg_wdata;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width   <= RST_WIDTH;
      cfg_r.height  <= RST_HEIGHT;
      cfg_r.depth   <= RST_DEPTH;
      cfg_r.lap     <= '0;
      cfg_r.damp    <= '0;
      cfg_r.norm    <= RST_NORM;
      cfg_r.force_g <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = en1;
  assign acc       = in_tvalid && en1;

  fws_fetch #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_fetch (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .acc         (acc),
    .pres_now    (in_tdata[31:0]),
    .pres_before (in_tdata[63:32]),
    .force_in    (in_tdata[95:64]),
    .is_padding  (in_tuser),
    .en1         (en1),
    .v1          (v1),
    .tap         (tap)
  );

  fws_arith u_arith (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .v1         (v1),
    .tap        (tap),
    .en1        (en1),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ src/fws_chk.sv @@
// ----------------------------------------------------------------------------
// fws_chk
// Port-level checks of the stencil stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "fdtd_wave_stencil_3d_assert.svh"

module fws_chk (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tready,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [fws_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              out_tlast
);

  `FWS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `FWS_ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast))
  // an empty or draining output stage never blocks the input
  `FWS_ASSERT_IMP(a_in_free, clk, rst_n, !out_tvalid || out_tready, in_tready)
  `FWS_ASSERT_RNXT(a_rst_empty, clk, !rst_n, !out_tvalid)

endmodule

bind fdtd_wave_stencil_3d fws_chk u_fws_chk (.*);
